// ===== rtl/core/modem_response_recognizer_top_assert.svh =====
// Assertion macros for the modem response recognizer.
`ifndef MODEM_RESPONSE_RECOGNIZER_TOP_ASSERT_SVH
`define MODEM_RESPONSE_RECOGNIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define MRR_CHECK(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("mrr check failed");
// Check that a condition implies another one at the same edge.
`define MRR_CHECK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrr implication failed");
// Check that a condition implies another one at the next edge.
`define MRR_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrr next-cycle check failed");
`else
`define MRR_CHECK(lbl, expr)
`define MRR_CHECK_IMPL(lbl, ante, cons)
`define MRR_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mrr_pkg.sv =====
// Shared types and constants for the modem response recognizer.
`timescale 1ns / 1ps
package mrr_pkg;

    // Capture buffer geometry (depth must be even)
    localparam int BUF_DEPTH = 128;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int BANK_W    = ADDR_W - 1;
    localparam int BANK_DEPTH = BUF_DEPTH / 2;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 7;
    localparam int FILL_W  = 7;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_RX        = 2'd0,
        CMD_CLR_BUF   = 2'd1,
        CMD_CLR_FLAGS = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    // Matcher states
    typedef enum logic [3:0] {
        MS_IDLE = 4'd0,
        MS_O    = 4'd1,
        MS_E    = 4'd2,
        MS_ER   = 4'd3,
        MS_ERR  = 4'd4,
        MS_ERRO = 4'd5,
        MS_R    = 4'd6,
        MS_RI   = 4'd7,
        MS_RIN  = 4'd8
    } t_match_state;

    // Sticky status flags
    typedef struct packed {
        logic prompt;
        logic ring;
        logic error;
        logic ok;
    } t_flags;

    // Characters the matcher looks for
    localparam logic [BYTE_W-1:0] CH_O      = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_K      = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_E      = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_I      = 8'h49;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h3E;

endpackage

// ===== rtl/core/mrr_matcher.sv =====
// Response matcher: state register and sticky flags for OK, ERROR, RING and prompt.
`timescale 1ns / 1ps
module mrr_matcher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_clr_flags,
    input  logic [mrr_pkg::BYTE_W-1:0] i_byte,
    output mrr_pkg::t_flags            o_flags_nxt
);

    mrr_pkg::t_match_state r_state;
    mrr_pkg::t_match_state n_state;
    mrr_pkg::t_flags       r_flags;
    mrr_pkg::t_flags       n_flags;

    // Hold state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrr_pkg::MS_IDLE;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
        end
    end

    // Advance the matcher by one byte; a mismatch drops back to idle untested
    always_comb begin
        n_state = r_state;
        n_flags = r_flags;
        if (i_clr_flags) begin
            n_flags = '0;
        end else if (i_step) begin
            n_state = mrr_pkg::MS_IDLE;
            case (r_state)
                mrr_pkg::MS_IDLE: begin
                    if (i_byte == mrr_pkg::CH_O) n_state = mrr_pkg::MS_O;
                    else if (i_byte == mrr_pkg::CH_E) n_state = mrr_pkg::MS_E;
                    else if (i_byte == mrr_pkg::CH_R) n_state = mrr_pkg::MS_R;
                    else if (i_byte == mrr_pkg::CH_PROMPT) n_flags.prompt = 1'b1;
                end
                mrr_pkg::MS_O: begin
                    if (i_byte == mrr_pkg::CH_K) n_flags.ok = 1'b1;
                end
                mrr_pkg::MS_E: begin
                    if (i_byte == mrr_pkg::CH_R) n_state = mrr_pkg::MS_ER;
                end
                mrr_pkg::MS_ER: begin
                    if (i_byte == mrr_pkg::CH_R) n_state = mrr_pkg::MS_ERR;
                end
                mrr_pkg::MS_ERR: begin
                    if (i_byte == mrr_pkg::CH_O) n_state = mrr_pkg::MS_ERRO;
                end
                mrr_pkg::MS_ERRO: begin
                    if (i_byte == mrr_pkg::CH_R) n_flags.error = 1'b1;
                end
                mrr_pkg::MS_R: begin
                    if (i_byte == mrr_pkg::CH_I) n_state = mrr_pkg::MS_RI;
                end
                mrr_pkg::MS_RI: begin
                    if (i_byte == mrr_pkg::CH_N) n_state = mrr_pkg::MS_RIN;
                end
                mrr_pkg::MS_RIN: begin
                    if (i_byte == mrr_pkg::CH_G) n_flags.ring = 1'b1;
                end
                default: begin
                    n_state = mrr_pkg::MS_IDLE;
                end
            endcase
        end
    end

    assign o_flags_nxt = n_flags;

endmodule

// ===== rtl/core/mrr_capture_buf.sv =====
// Capture buffer: even and odd banks so a byte and its terminator land together.
`timescale 1ns / 1ps
module mrr_capture_buf (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [mrr_pkg::ADDR_W-1:0] i_wr_ptr,
    input  logic [mrr_pkg::BYTE_W-1:0] i_wr_byte,
    input  logic                       i_clr,
    input  logic                       i_rd_en,
    input  logic [mrr_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [mrr_pkg::BYTE_W-1:0] o_rd_data
);

    logic [mrr_pkg::BYTE_W-1:0] bank_even [mrr_pkg::BANK_DEPTH];
    logic [mrr_pkg::BYTE_W-1:0] bank_odd  [mrr_pkg::BANK_DEPTH];

    logic [mrr_pkg::ADDR_W-1:0] ptr_inc;
    logic                       even_we;
    logic [mrr_pkg::BANK_W-1:0] even_addr;
    logic [mrr_pkg::BYTE_W-1:0] even_data;
    logic                       odd_we;
    logic [mrr_pkg::BANK_W-1:0] odd_addr;
    logic [mrr_pkg::BYTE_W-1:0] odd_data;
    logic [mrr_pkg::BYTE_W-1:0] r_rd_even;
    logic [mrr_pkg::BYTE_W-1:0] r_rd_odd;
    logic                       r_rd_par;

    assign ptr_inc = i_wr_ptr + mrr_pkg::ADDR_W'(1);

    // Route the byte to its bank and the terminator to the other one
    always_comb begin
        even_we   = 1'b0;
        even_addr = '0;
        even_data = '0;
        odd_we    = 1'b0;
        odd_addr  = '0;
        odd_data  = '0;
        if (i_wr_en) begin
            even_we = 1'b1;
            odd_we  = 1'b1;
            if (i_wr_ptr[0]) begin
                odd_addr  = i_wr_ptr[mrr_pkg::ADDR_W-1:1];
                odd_data  = i_wr_byte;
                even_addr = ptr_inc[mrr_pkg::ADDR_W-1:1];
            end else begin
                even_addr = i_wr_ptr[mrr_pkg::ADDR_W-1:1];
                even_data = i_wr_byte;
                odd_addr  = ptr_inc[mrr_pkg::ADDR_W-1:1];
            end
        end else if (i_clr) begin
            // terminator at entry zero
            even_we = 1'b1;
        end
    end

    // Write the banks
    always_ff @(posedge i_clk) begin
        if (even_we) bank_even[even_addr] <= even_data;
        if (odd_we) bank_odd[odd_addr] <= odd_data;
    end

    // Register the read of both banks
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_even <= bank_even[i_rd_addr[mrr_pkg::ADDR_W-1:1]];
            r_rd_odd  <= bank_odd[i_rd_addr[mrr_pkg::ADDR_W-1:1]];
            r_rd_par  <= i_rd_addr[0];
        end
    end

    assign o_rd_data = r_rd_par ? r_rd_odd : r_rd_even;

endmodule

// ===== rtl/core/modem_response_recognizer_top.sv =====
// Modem response recognizer: input register, matcher, capture buffer and result register.
// Usage:
//   Input channel i_valid / o_stall carries one beat per command: receive a byte,
//   clear the capture buffer, clear the sticky flags, or read one buffer entry.
//   A beat is taken at a rising edge with i_valid high and o_stall low.
//   Output channel o_valid / i_stall returns one beat per input beat, in order,
//   with the four sticky flags, the fill level, the drop indication and read data.
// Path: a taken beat passes the input register, then the result register, which
//   loads it once the output side is free (one input register, one result register).
// Throughput: one beat per cycle while i_stall does not hold a result; matcher step,
//   buffer write and buffer read all finish between the input and result registers.
// Buffer: two banks (even and odd entries) of BUF_DEPTH/2 bytes each, so a byte
//   and its zero terminator are written in the same cycle.
// Reset: synchronous, active low; clears the matcher, flags, fill level and both
//   valid bits. Buffer contents are left as they are.
// Stall: while i_stall holds a result, the result register and the input register
//   hold; o_stall rises only when the input register is full and cannot move.
`timescale 1ns / 1ps
`include "modem_response_recognizer_top_assert.svh"
module modem_response_recognizer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [mrr_pkg::CMD_W-1:0]  i_command,
    input  logic [mrr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [mrr_pkg::IDX_W-1:0]  i_read_index,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_ok_seen,
    output logic                       o_error_seen,
    output logic                       o_ring_seen,
    output logic                       o_prompt_seen,
    output logic [mrr_pkg::FILL_W-1:0] o_fill_level,
    output logic                       o_byte_dropped,
    output logic [mrr_pkg::BYTE_W-1:0] o_read_data
);

    localparam int IDX_WIDE_W  = mrr_pkg::ADDR_W + mrr_pkg::IDX_W;
    localparam int FILL_WIDE_W = mrr_pkg::ADDR_W + mrr_pkg::FILL_W;

    // Input register
    logic                       r_in_valid;
    mrr_pkg::t_cmd              r_in_cmd;
    logic [mrr_pkg::BYTE_W-1:0] r_in_byte;
    logic [mrr_pkg::IDX_W-1:0]  r_in_idx;

    // Buffer pointer and result register
    logic [mrr_pkg::ADDR_W-1:0] r_wp;
    logic [mrr_pkg::ADDR_W-1:0] n_wp;
    logic                       r_out_valid;
    mrr_pkg::t_cmd              r_out_cmd;
    mrr_pkg::t_flags            r_out_flags;
    logic                       r_out_dropped;
    logic                       r_out_rd_sel;

    logic                       adv;
    logic                       take_in;
    logic                       work;
    logic                       has_room;
    logic                       rx_ok;
    logic                       rx_drop;
    logic                       clr_buf;
    logic                       clr_flags;
    logic                       rd_cmd;
    logic [IDX_WIDE_W-1:0]      idx_wide;
    logic                       idx_in_range;
    logic [FILL_WIDE_W-1:0]     fill_wide;
    mrr_pkg::t_flags            flags_nxt;
    logic [mrr_pkg::BYTE_W-1:0] buf_rd_data;

    // Handshake: the pipe moves when the result register is free or drained
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign take_in = i_valid && !o_stall;
    assign work    = r_in_valid && adv;

    // Decode the held command
    assign has_room  = r_wp < mrr_pkg::ADDR_W'(mrr_pkg::BUF_DEPTH - 1);
    assign rx_ok     = work && (r_in_cmd == mrr_pkg::CMD_RX) && has_room;
    assign rx_drop   = (r_in_cmd == mrr_pkg::CMD_RX) && !has_room;
    assign clr_buf   = work && (r_in_cmd == mrr_pkg::CMD_CLR_BUF);
    assign clr_flags = work && (r_in_cmd == mrr_pkg::CMD_CLR_FLAGS);
    assign rd_cmd    = r_in_cmd == mrr_pkg::CMD_READ;

    assign idx_wide     = {mrr_pkg::ADDR_W'(0), r_in_idx};
    assign idx_in_range = idx_wide < IDX_WIDE_W'(mrr_pkg::BUF_DEPTH);

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv || !r_in_valid) begin
            r_in_valid <= take_in;
        end
        if (take_in) begin
            r_in_cmd  <= mrr_pkg::t_cmd'(i_command);
            r_in_byte <= i_rx_byte;
            r_in_idx  <= i_read_index;
        end
    end

    // Advance the write pointer
    always_comb begin
        n_wp = r_wp;
        if (rx_ok) begin
            n_wp = r_wp + mrr_pkg::ADDR_W'(1);
        end else if (clr_buf) begin
            n_wp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else begin
            r_wp <= n_wp;
        end
    end

    mrr_matcher u_matcher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (rx_ok),
        .i_clr_flags (clr_flags),
        .i_byte      (r_in_byte),
        .o_flags_nxt (flags_nxt)
    );

    mrr_capture_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (rx_ok),
        .i_wr_ptr  (r_wp),
        .i_wr_byte (r_in_byte),
        .i_clr     (clr_buf),
        .i_rd_en   (work && rd_cmd),
        .i_rd_addr (idx_wide[mrr_pkg::ADDR_W-1:0]),
        .o_rd_data (buf_rd_data)
    );

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
        if (work) begin
            r_out_cmd     <= r_in_cmd;
            r_out_flags   <= flags_nxt;
            r_out_dropped <= rx_drop;
            r_out_rd_sel  <= rd_cmd && idx_in_range;
        end
    end

    // Drive the result ports; fill level follows the pointer, which holds with the beat
    assign fill_wide      = {mrr_pkg::FILL_W'(0), r_wp};
    assign o_valid        = r_out_valid;
    assign o_ok_seen      = r_out_flags.ok;
    assign o_error_seen   = r_out_flags.error;
    assign o_ring_seen    = r_out_flags.ring;
    assign o_prompt_seen  = r_out_flags.prompt;
    assign o_fill_level   = fill_wide[mrr_pkg::FILL_W-1:0];
    assign o_byte_dropped = r_out_dropped;
    assign o_read_data    = r_out_rd_sel ? buf_rd_data : '0;

    // Pointer never passes the last buffer entry, which takes the terminator when full
    `MRR_CHECK(a_wp_range, r_wp <= mrr_pkg::ADDR_W'(mrr_pkg::BUF_DEPTH - 1))
    // A dropped byte only happens on a full buffer
    `MRR_CHECK_IMPL(a_drop_full, o_valid && o_byte_dropped, r_wp == mrr_pkg::ADDR_W'(mrr_pkg::BUF_DEPTH - 1))
    // A clear-buffer result reports an empty buffer
    `MRR_CHECK_IMPL(a_clr_empty, o_valid && r_out_cmd == mrr_pkg::CMD_CLR_BUF, o_fill_level == '0)
    // A stalled result keeps the pointer still
    `MRR_CHECK_NEXT(a_stall_hold, o_valid && i_stall && i_rst_n, $stable(r_wp))

endmodule

// ===== dv/mrr_checker.sv =====
// Status checker for the modem response recognizer: tracks commands, predicts status beats.
`timescale 1ns / 1ps
module mrr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  logic                       i_cmd_stall,
    input  logic [mrr_pkg::CMD_W-1:0]  i_command,
    input  logic [mrr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [mrr_pkg::IDX_W-1:0]  i_read_index,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_stall,
    input  logic                       i_ok_seen,
    input  logic                       i_error_seen,
    input  logic                       i_ring_seen,
    input  logic                       i_prompt_seen,
    input  logic [mrr_pkg::FILL_W-1:0] i_fill_level,
    input  logic                       i_byte_dropped,
    input  logic [mrr_pkg::BYTE_W-1:0] i_read_data,
    output int                         o_mismatch_count,
    output int                         o_pending
);
    import mrr_pkg::*;

    // One status beat as the block returns it
    typedef struct packed {
        t_flags             flags;
        logic [FILL_W-1:0]  fill;
        logic               dropped;
        logic [BYTE_W-1:0]  rdata;
    } t_status_beat;

    // Shadow of the block state
    t_match_state       match_st;
    t_flags             flags_q;
    int unsigned        wr_ptr;
    logic [BYTE_W-1:0]  capture_copy [BUF_DEPTH];
    t_status_beat       status_q [$];

    int mismatches = 0;
    int pend_cnt   = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending        = pend_cnt;

    // Apply one command to the shadow state and return the status beat it yields
    function automatic t_status_beat apply_command(t_cmd cmd, logic [BYTE_W-1:0] b,
                                                   logic [IDX_W-1:0] idx);
        t_status_beat beat;
        t_match_state nxt;
        beat = '0;
        nxt  = MS_IDLE;
        case (cmd)
            CMD_RX: begin
                // the terminator must always fit, so the last entry never takes a byte
                if (wr_ptr < BUF_DEPTH - 1) begin
                    capture_copy[wr_ptr] = b;
                    // a byte that breaks a partial match is not tested again
                    case (match_st)
                        MS_IDLE: begin
                            if (b == CH_O) nxt = MS_O;
                            else if (b == CH_E) nxt = MS_E;
                            else if (b == CH_R) nxt = MS_R;
                            else if (b == CH_PROMPT) flags_q.prompt = 1'b1;
                        end
                        MS_O:    if (b == CH_K) flags_q.ok = 1'b1;
                        MS_E:    if (b == CH_R) nxt = MS_ER;
                        MS_ER:   if (b == CH_R) nxt = MS_ERR;
                        MS_ERR:  if (b == CH_O) nxt = MS_ERRO;
                        MS_ERRO: if (b == CH_R) flags_q.error = 1'b1;
                        MS_R:    if (b == CH_I) nxt = MS_RI;
                        MS_RI:   if (b == CH_N) nxt = MS_RIN;
                        MS_RIN:  if (b == CH_G) flags_q.ring = 1'b1;
                        default: ;
                    endcase
                    match_st = nxt;
                    wr_ptr++;
                    capture_copy[wr_ptr] = '0;
                end else begin
                    beat.dropped = 1'b1;
                end
            end
            CMD_CLR_BUF: begin
                wr_ptr = 0;
                capture_copy[0] = '0;
            end
            CMD_CLR_FLAGS: flags_q = '0;
            default: begin
                if (idx < BUF_DEPTH) beat.rdata = capture_copy[idx];
            end
        endcase
        beat.flags = flags_q;
        beat.fill  = FILL_W'(wr_ptr);
        return beat;
    endfunction

    // Compare returned beats first, then record the command taken at the same edge
    always @(posedge i_clk) begin : watch_channels
        t_status_beat got_beat;
        t_status_beat want_beat;
        if (!i_rst_n) begin
            match_st = MS_IDLE;
            flags_q  = '0;
            wr_ptr   = 0;
            status_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got_beat = {i_prompt_seen, i_ring_seen, i_error_seen, i_ok_seen,
                            i_fill_level, i_byte_dropped, i_read_data};
                if (status_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: status beat with none outstanding: flags %b fill %0d",
                                 $time, got_beat.flags, got_beat.fill);
                    mismatches++;
                end else begin
                    want_beat = status_q.pop_front();
                    if (got_beat !== want_beat) begin
                        if (mismatches < 10)
                            $display({"%0t: status mismatch: flags exp %b got %b, ",
                                      "fill exp %0d got %0d, dropped exp %b got %b, ",
                                      "rdata exp %02h got %02h"}, $time,
                                     want_beat.flags, got_beat.flags,
                                     want_beat.fill, got_beat.fill,
                                     want_beat.dropped, got_beat.dropped,
                                     want_beat.rdata, got_beat.rdata);
                        mismatches++;
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall)
                status_q.push_back(apply_command(t_cmd'(i_command), i_rx_byte, i_read_index));
        end
        pend_cnt <= status_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the modem response recognizer: clock, reset, command beats and verdict.
`timescale 1ns / 1ps
module tb;
    import mrr_pkg::*;

    localparam int RANDOM_BEATS = 750;
    localparam int CYCLE_LIMIT  = 400000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cmd_valid  = 1'b0;
    logic               cmd_stall;
    logic [CMD_W-1:0]   command    = CMD_RX;
    logic [BYTE_W-1:0]  rx_byte    = '0;
    logic [IDX_W-1:0]   read_index = '0;
    logic               rsp_valid;
    logic               rsp_stall  = 1'b0;
    logic               ok_seen;
    logic               error_seen;
    logic               ring_seen;
    logic               prompt_seen;
    logic [FILL_W-1:0]  fill_level;
    logic               byte_dropped;
    logic [BYTE_W-1:0]  read_data;
    int                 mismatches;
    int                 pending;

    // Sender-side view of the buffer: which entries hold a known value
    int unsigned        sh_fill = 0;
    bit                 sh_written [BUF_DEPTH];
    int unsigned        sent_beats = 0;
    bit                 quiet = 1'b0;
    int unsigned        stall_run = 0;
    int unsigned        cycles = 0;

    string responses [8] = '{"OK", "ERROR", "RING", ">", "ERRO", "RIN", "\r\n", "AT+X"};

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    modem_response_recognizer_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (cmd_valid),
        .o_stall        (cmd_stall),
        .i_command      (command),
        .i_rx_byte      (rx_byte),
        .i_read_index   (read_index),
        .o_valid        (rsp_valid),
        .i_stall        (rsp_stall),
        .o_ok_seen      (ok_seen),
        .o_error_seen   (error_seen),
        .o_ring_seen    (ring_seen),
        .o_prompt_seen  (prompt_seen),
        .o_fill_level   (fill_level),
        .o_byte_dropped (byte_dropped),
        .o_read_data    (read_data)
    );

    mrr_checker status_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd_stall      (cmd_stall),
        .i_command        (command),
        .i_rx_byte        (rx_byte),
        .i_read_index     (read_index),
        .i_rsp_valid      (rsp_valid),
        .i_rsp_stall      (rsp_stall),
        .i_ok_seen        (ok_seen),
        .i_error_seen     (error_seen),
        .i_ring_seen      (ring_seen),
        .i_prompt_seen    (prompt_seen),
        .i_fill_level     (fill_level),
        .i_byte_dropped   (byte_dropped),
        .i_read_data      (read_data),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one command beat and hold it until the block takes it
    task automatic send_beat(t_cmd cmd, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid  <= 1'b1;
        command    <= cmd;
        rx_byte    <= b;
        read_index <= idx;
        case (cmd)
            CMD_RX: begin
                if (sh_fill < BUF_DEPTH - 1) begin
                    sh_written[sh_fill] = 1'b1;
                    sh_fill++;
                    sh_written[sh_fill] = 1'b1;
                end
            end
            CMD_CLR_BUF: begin
                sh_fill = 0;
                sh_written[0] = 1'b1;
            end
            default: ;
        endcase
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        sent_beats++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(CMD_RX, s[i], IDX_W'($urandom));
    endtask

    // Read a random entry that has been written since reset, else clear the flags
    task automatic send_read();
        int unsigned idx;
        if (!sh_written[0]) begin
            send_beat(CMD_CLR_FLAGS, BYTE_W'($urandom), IDX_W'($urandom));
        end else begin
            idx = $urandom_range(0, BUF_DEPTH - 1);
            if (!sh_written[idx]) idx = $urandom_range(0, sh_fill);
            send_beat(CMD_READ, BYTE_W'($urandom), IDX_W'(idx));
        end
    endtask

    // Drop valid and hold off until every status beat has come back
    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Receiver stall: runs of free and stalled cycles
    always @(negedge clk) begin
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (quiet || $urandom_range(0, 99) < 60) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 6);
        end else begin
            rsp_stall <= 1'b1;
            stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned base;
        int unsigned next_phase;
        int unsigned r;
        bit          paused;
        string       word;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: each response, broken matches, byte extremes, reads and clears
        send_text("OK");
        send_beat(CMD_CLR_FLAGS, BYTE_W'($urandom), IDX_W'($urandom));
        send_text("OOK");
        send_text("ERROR");
        send_text("RING");
        send_text("R>");
        send_text(">");
        send_beat(CMD_RX, 8'h00, 7'h7F);
        send_beat(CMD_RX, 8'hFF, 7'h00);
        send_beat(CMD_READ, 8'hFF, 7'd18);
        send_beat(CMD_READ, 8'h00, 7'd19);
        send_beat(CMD_CLR_BUF, BYTE_W'($urandom), IDX_W'($urandom));
        send_beat(CMD_READ, BYTE_W'($urandom), 7'd0);
        send_beat(CMD_CLR_FLAGS, BYTE_W'($urandom), IDX_W'($urandom));

        // Random: mostly whole or damaged responses, with noise, reads and clears
        base       = sent_beats;
        next_phase = sent_beats;
        paused     = 1'b0;
        while (sent_beats - base < RANDOM_BEATS) begin
            if (sent_beats >= next_phase) begin
                quiet      = ($urandom_range(0, 3) == 0);
                next_phase = sent_beats + 60;
            end
            if (!paused && sent_beats - base >= RANDOM_BEATS / 2) begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 199);
            if (r < 3) begin
                send_beat(CMD_CLR_BUF, BYTE_W'($urandom), IDX_W'($urandom));
            end else if (r < 15) begin
                send_beat(CMD_CLR_FLAGS, BYTE_W'($urandom), IDX_W'($urandom));
            end else if (r < 45) begin
                send_read();
            end else if (r < 65) begin
                send_beat(CMD_RX, BYTE_W'($urandom), IDX_W'($urandom));
            end else begin
                word = responses[$urandom_range(0, 7)];
                // damage one character now and then
                if ($urandom_range(0, 4) == 0)
                    word[$urandom_range(0, word.len() - 1)] = 8'($urandom_range(1, 255));
                send_text(word);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
